FILE: src/hds_pkg.sv
// hds_pkg: shared widths, reset values, codes and the arctangent table
// for the hysteresis differential steering block
// no dependencies
package hds_pkg;

    // field widths
    localparam int HW       = 16;   // heading components, signed Q8.8
    localparam int CFG_W    = 15;   // configuration registers
    localparam int SPD_W    = 17;   // wheel speeds, signed Q9.8
    localparam int ANG_W    = 16;   // binary angle, 32768 = pi
    localparam int MODE_W   = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // cordic datapath
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN  = 24;
    localparam int ATAN_IW   = 5;
    localparam int XW        = 27;  // signed x/y working width, Q8.16 plus growth
    localparam int XU_W      = 25;  // final magnitude, always below 2^25
    localparam int PRE_SHIFT = 8;
    localparam logic [ANG_W-1:0] ANG_QUARTER     = 16'h4000;
    localparam logic [ANG_W-1:0] ANG_NEG_QUARTER = 16'hC000;

    // length scaling: len = (mag * 1/K + 2^23) >> 24
    localparam int GAIN_W    = 16;
    localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;
    localparam int PROD_W    = XU_W + GAIN_W;
    localparam int LEN_SHIFT = 24;
    localparam int LEN_W     = PROD_W - LEN_SHIFT;
    localparam logic [PROD_W-1:0] LEN_ROUND = PROD_W'(1) << (LEN_SHIFT - 1);

    // divider: quotient never exceeds base speed
    localparam int DIV_QW = 16;
    localparam int DIVD_W = DIV_QW + CFG_W;

    // register reset values
    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 15'd2560;
    localparam logic [CFG_W-1:0] HARD_THR_RST  = 15'd16384;
    localparam logic [CFG_W-1:0] SOFT_THR_RST  = 15'd12743;
    localparam logic [CFG_W-1:0] NO_THR_RST    = 15'd1820;

    typedef enum logic [MODE_W-1:0] {
        TURN_NONE = 2'd0,
        TURN_SOFT = 2'd1,
        TURN_HARD = 2'd2
    } turn_t;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_HARD_THR  = 2'd1,
        CFG_SOFT_THR  = 2'd2,
        CFG_NO_THR    = 2'd3
    } cfg_idx_t;

    // atan(2^-i) in binary angle units, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_lookup(input logic [ATAN_IW-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 16'd8192;
            5'd1:    val = 16'd4836;
            5'd2:    val = 16'd2555;
            5'd3:    val = 16'd1297;
            5'd4:    val = 16'd651;
            5'd5:    val = 16'd326;
            5'd6:    val = 16'd163;
            5'd7:    val = 16'd81;
            5'd8:    val = 16'd41;
            5'd9:    val = 16'd20;
            5'd10:   val = 16'd10;
            5'd11:   val = 16'd5;
            5'd12:   val = 16'd3;
            5'd13:   val = 16'd1;
            5'd14:   val = 16'd1;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: src/hysteresis_differential_steering.sv
// hysteresis_differential_steering: heading vector to left/right wheel speeds
// each request runs the cordic loop, the length, clamp and scale steps and, for a
// soft turn with a nonzero hard threshold, the divider, then goes to the output register
// s_tready is low while one is in work, so a new request is taken only when idle;
// a finished result may wait in the output register while the next one runs
// reset: synchronous active-low aresetn clears the turn state to no turn and
// loads the register defaults; depends on hds_pkg, hds_cordic, hds_div
module hysteresis_differential_steering #(
    parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_index,
    input  logic [hds_pkg::CFG_W-1:0]            cfg_wdata,
    // heading requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] heading_x, [31:16] heading_y
    input  logic [hds_pkg::IN_TDATA_W-1:0]       s_tdata,
    // wheel speed results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [16:0] left_speed, [33:17] right_speed, [35:34] turn_mode, [39:36] zero
    output logic [hds_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import hds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_LEN,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    turn_t             turn_reg;
    logic [CFG_W-1:0]  max_speed_reg, hard_thr_reg, soft_thr_reg, no_thr_reg;
    logic [ANG_W-1:0]  ang_reg, abs_reg;
    logic [PROD_W-1:0] mul_reg;
    logic [CFG_W-1:0]  base_reg;
    logic [DIV_QW-1:0] delta_reg;
    logic              m_tvalid_reg;
    logic [SPD_W-1:0]  left_reg, right_reg;
    turn_t             mode_reg;

    logic              accept;
    logic              cordic_done, div_done;
    logic [XU_W-1:0]   cordic_mag;
    logic [ANG_W-1:0]  cordic_ang;
    logic [DIV_QW-1:0] div_quo;
    logic [DIVD_W-1:0] div_dividend;
    logic [XU_W-1:0]   mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [PROD_W-1:0] len_sum;
    logic [LEN_W-1:0]  len_val;
    logic [CFG_W-1:0]  base_val;
    turn_t             turn_next;
    logic [SPD_W-1:0]  base_ext, delta_ext, max_ext;
    logic [SPD_W-1:0]  spd1, spd2;
    logic              ang_pos;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // angle and magnitude
    hds_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hx      (s_tdata[HW-1:0]),
        .hy      (s_tdata[2*HW-1:HW]),
        .done    (cordic_done),
        .mag     (cordic_mag),
        .angle   (cordic_ang)
    );

    // soft turn speed offset
    assign div_dividend = mul_reg[DIVD_W-1:0] + DIVD_W'(hard_thr_reg >> 1);

    hds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (div_dividend),
        .divisor  (hard_thr_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // shared multiplier operand select
    always_comb begin
        if (state_reg == ST_LEN) begin
            mul_a = cordic_mag;
            mul_b = INV_GAIN;
        end else begin
            mul_a = XU_W'(base_reg);
            mul_b = abs_reg;
        end
    end

    // rounded length, clamped to max speed
    assign len_sum  = mul_reg + LEN_ROUND;
    assign len_val  = len_sum[PROD_W-1:LEN_SHIFT];
    assign base_val = (len_val < LEN_W'(max_speed_reg)) ? len_val[CFG_W-1:0] : max_speed_reg;

    // hysteresis: checks run hard, then soft, then none
    always_comb begin
        turn_next = turn_reg;
        if (turn_next == TURN_HARD) begin
            if (abs_reg <= ANG_W'(soft_thr_reg)) turn_next = TURN_SOFT;
        end
        if (turn_next == TURN_SOFT) begin
            if (abs_reg > ANG_W'(hard_thr_reg))     turn_next = TURN_HARD;
            else if (abs_reg <= ANG_W'(no_thr_reg)) turn_next = TURN_NONE;
        end
        if (turn_next == TURN_NONE) begin
            if (abs_reg > ANG_W'(hard_thr_reg))    turn_next = TURN_HARD;
            else if (abs_reg > ANG_W'(no_thr_reg)) turn_next = TURN_SOFT;
        end
    end

    // wheel speeds from the new turn state
    assign base_ext  = SPD_W'(base_reg);
    assign delta_ext = SPD_W'(delta_reg);
    assign max_ext   = SPD_W'(max_speed_reg);
    assign ang_pos   = !ang_reg[ANG_W-1] && (ang_reg != '0);

    always_comb begin
        case (turn_reg)
            TURN_SOFT: begin
                spd1 = base_ext - delta_ext;
                spd2 = base_ext + delta_ext;
            end
            TURN_HARD: begin
                spd1 = -max_ext;
                spd2 = max_ext;
            end
            default: begin
                spd1 = base_ext;
                spd2 = base_ext;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST;
            hard_thr_reg  <= HARD_THR_RST;
            soft_thr_reg  <= SOFT_THR_RST;
            no_thr_reg    <= NO_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_wdata;
                CFG_HARD_THR:  hard_thr_reg  <= cfg_wdata;
                CFG_SOFT_THR:  soft_thr_reg  <= cfg_wdata;
                CFG_NO_THR:    no_thr_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            turn_reg     <= TURN_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output valid: load from the finish state, clear when taken
            if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    if (cordic_done) state_reg <= ST_LEN;
                end
                ST_LEN: begin
                    mul_reg   <= mul_a * mul_b;
                    ang_reg   <= cordic_ang;
                    abs_reg   <= cordic_ang[ANG_W-1] ? -cordic_ang : cordic_ang;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    base_reg  <= base_val;
                    turn_reg  <= turn_next;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    mul_reg <= mul_a * mul_b;
                    if (turn_reg == TURN_SOFT && hard_thr_reg != '0) begin
                        state_reg <= ST_DIV_GO;
                    end else begin
                        delta_reg <= '0;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        delta_reg <= div_quo;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        left_reg     <= ang_pos ? spd1 : spd2;
                        right_reg    <= ang_pos ? spd2 : spd1;
                        mode_reg     <= turn_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2*SPD_W - MODE_W){1'b0}}, mode_reg, right_reg, left_reg};

    // no new request while one is in work
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while busy");

    // unit completions line up with the sequencer
    a_cordic_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_ROT))
        else $error("cordic finished outside its wait state");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // soft turn offset never exceeds the base speed
    a_delta_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && turn_reg == TURN_SOFT) |-> (delta_reg <= DIV_QW'(base_reg)))
        else $error("soft turn offset above base speed");

    // hard turn spins in place
    a_hard_opposite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && mode_reg == TURN_HARD) |-> (SPD_W'(left_reg + right_reg) == '0))
        else $error("hard turn wheel speeds not opposite");

endmodule

FILE: src/hds_cordic.sv
// hds_cordic: iterative cordic vectoring unit, one micro-rotation per cycle
// gives the binary angle and the unscaled magnitude of a heading vector
// depends on hds_pkg
module hds_cordic #(
    parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [hds_pkg::HW-1:0]     hx,
    input  logic signed [hds_pkg::HW-1:0]     hy,
    output logic                              done,
    output logic [hds_pkg::XU_W-1:0]          mag,
    output logic [hds_pkg::ANG_W-1:0]         angle
);
    import hds_pkg::*;

    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic [ANG_W-1:0]     z_reg, z_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic signed [XW-1:0] x_ld, y_ld, dx, dy;
    logic [ANG_W-1:0]     atan_val;

    // scale inputs to Q8.16
    assign x_ld = {{(XW-HW-PRE_SHIFT){hx[HW-1]}}, hx, {PRE_SHIFT{1'b0}}};
    assign y_ld = {{(XW-HW-PRE_SHIFT){hy[HW-1]}}, hy, {PRE_SHIFT{1'b0}}};

    // shared shift and table lookup
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = atan_lookup(ATAN_IW'(step_reg));

    // pre-rotation on load, then one micro-rotation per cycle
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            if (x_ld < 0) begin
                if (y_ld >= 0) begin
                    x_next = y_ld;
                    y_next = -x_ld;
                    z_next = ANG_QUARTER;
                end else begin
                    x_next = -y_ld;
                    y_next = x_ld;
                    z_next = ANG_NEG_QUARTER;
                end
            end else begin
                x_next = x_ld;
                y_next = y_ld;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end else if (y_reg < 0) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // a negative x clamps the magnitude to zero
    assign done  = done_reg;
    assign mag   = x_reg[XW-1] ? '0 : x_reg[XU_W-1:0];
    assign angle = z_reg;

endmodule

FILE: src/hds_div.sv
// hds_div: restoring divider, one quotient bit per cycle
// the dividend must stay below divisor * 2^DIV_QW
// depends on hds_pkg
module hds_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [hds_pkg::DIVD_W-1:0]    dividend,
    input  logic [hds_pkg::CFG_W-1:0]     divisor,
    output logic                          done,
    output logic [hds_pkg::DIV_QW-1:0]    quotient
);
    import hds_pkg::*;

    localparam int CW = $clog2(DIV_QW);
    localparam logic [CW-1:0] LAST_BIT = CW'(DIV_QW - 1);

    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [CFG_W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CFG_W:0]    trial;
    logic              fits;

    // shared compare and subtract
    assign trial = {rem_reg, quo_reg[DIV_QW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[DIVD_W-1:DIV_QW];
            quo_next  = dividend[DIV_QW-1:0];
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? CFG_W'(trial - {1'b0, dsr_reg}) : trial[CFG_W-1:0];
            quo_next = {quo_reg[DIV_QW-2:0], fits};
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: bench/tb_hysteresis_differential_steering.sv
// tb_hysteresis_differential_steering: self-checking bench for the steering block
// directed table then randomized heading sweeps under several register settings;
// depends on hds_pkg and hysteresis_differential_steering
`timescale 1ns / 1ps

module tb_hysteresis_differential_steering;
    import hds_pkg::*;

    localparam int CORDIC_ITERS   = CORDIC_STEPS_DEF;
    localparam int SETTLE_CYCLES  = 2 * (CORDIC_ITERS + 24);
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_REQUESTS = 250;
    localparam int REPORT_MAX     = 10;
    localparam logic [CFG_W-1:0] REG_TOP = '1;

    typedef struct packed {
        logic [SPD_W-1:0] left;
        logic [SPD_W-1:0] right;
        turn_t            mode;
    } wheels_t;

    // one row of the directed table: a register write or a heading request
    typedef struct packed {
        bit               is_write;
        cfg_idx_t         idx;
        logic [CFG_W-1:0] val;
        logic [HW-1:0]    hx;
        logic [HW-1:0]    hy;
        bit               typed;
        wheels_t          want;
    } step_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [1:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [15:0] heading_x, [31:16] heading_y
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [16:0] left, [33:17] right, [35:34] turn_mode

    // steering model state and register copies
    turn_t            steer_state;
    logic [CFG_W-1:0] max_speed_r, hard_thr_r, soft_thr_r, no_thr_r;
    int atan_units [ATAN_LEN] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0,
                                  0, 0, 0, 0, 0, 0, 0, 0};

    wheels_t wheels_due [$];
    step_t   directed_steps [$];

    int fail_count      = 0;
    int headings_sent   = 0;
    int configs_written = 0;
    int mode_seen [3]   = '{0, 0, 0};
    int send_burst      = 0;
    int take_burst      = 0;
    int idle_cycles     = 0;
    int sweep_left      = 0;
    int sweep_r, sweep_p, sweep_step;

    hysteresis_differential_steering #(
        .CORDIC_STEPS(CORDIC_ITERS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // cordic angle and length, hysteresis update, then wheel speeds
    function automatic wheels_t predict_wheels(input logic signed [HW-1:0] hx,
                                               input logic signed [HW-1:0] hy);
        longint x, y, dx, dy, t, len, mag, base, top, hard, soft_lim, notr, delta, s1, s2;
        int z;
        logic signed [ANG_W-1:0] ang;
        wheels_t w;
        x = longint'(hx) * 256;
        y = longint'(hy) * 256;
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 16384;
            end else begin
                x = -y;
                y = t;
                z = -16384;
            end
        end
        for (int i = 0; i < CORDIC_ITERS && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_units[i];
            end else if (y < 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_units[i];
            end
        end
        ang = z[ANG_W-1:0];
        mag = (ang < 0) ? -longint'(ang) : longint'(ang);
        if (x < 0) x = 0;
        len = (x * 39797 + (longint'(1) << 23)) >>> 24;
        top      = max_speed_r;
        hard     = hard_thr_r;
        soft_lim = soft_thr_r;
        notr     = no_thr_r;
        base = (len < top) ? len : top;

        // hysteresis checks, in order
        if (steer_state == TURN_HARD && mag <= soft_lim) steer_state = TURN_SOFT;
        if (steer_state == TURN_SOFT) begin
            if (mag > hard) steer_state = TURN_HARD;
            else if (mag <= notr) steer_state = TURN_NONE;
        end
        if (steer_state == TURN_NONE) begin
            if (mag > hard) steer_state = TURN_HARD;
            else if (mag > notr) steer_state = TURN_SOFT;
        end

        case (steer_state)
            TURN_SOFT: begin
                delta = (hard != 0) ? (base * mag + hard / 2) / hard : 0;
                s1 = base - delta;
                s2 = base + delta;
            end
            TURN_HARD: begin
                s1 = -top;
                s2 = top;
            end
            default: begin
                s1 = base;
                s2 = base;
            end
        endcase

        // positive angle turns left, zero goes right
        w.left  = (ang > 0) ? s1[SPD_W-1:0] : s2[SPD_W-1:0];
        w.right = (ang > 0) ? s2[SPD_W-1:0] : s1[SPD_W-1:0];
        w.mode  = steer_state;
        return w;
    endfunction

    // per-request wait, with occasional stretches of back-to-back traffic
    function automatic int next_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [CFG_W-1:0] rand_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REG_TOP;
            default: return CFG_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [HW-1:0] noise_comp();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return HW'($urandom());
        endcase
    endfunction

    // mostly slow sweeps around a square path, so the angle crosses thresholds
    // both ways; the rest is unstructured noise
    function automatic void next_heading(output logic [HW-1:0] hx, output logic [HW-1:0] hy);
        int span, side, off;
        if (sweep_left == 0 && $urandom_range(0, 3) != 0) begin
            sweep_left = $urandom_range(10, 40);
            sweep_r    = $urandom_range(0, 1) ? $urandom_range(1, 255)
                                              : $urandom_range(256, 32767);
            sweep_p    = $urandom_range(0, 8 * sweep_r - 1);
            sweep_step = $urandom_range(1, sweep_r / 8 + 1);
            if ($urandom_range(0, 1)) sweep_step = -sweep_step;
        end
        if (sweep_left > 0) begin
            sweep_left--;
            span = 2 * sweep_r;
            side = sweep_p / span;
            off  = sweep_p % span - sweep_r;
            case (side)
                0: begin
                    hx = HW'(sweep_r);
                    hy = HW'(off);
                end
                1: begin
                    hx = HW'(-off);
                    hy = HW'(sweep_r);
                end
                2: begin
                    hx = HW'(-sweep_r);
                    hy = HW'(-off);
                end
                default: begin
                    hx = HW'(off);
                    hy = HW'(-sweep_r);
                end
            endcase
            sweep_p = (sweep_p + sweep_step + 8 * sweep_r) % (8 * sweep_r);
        end else begin
            hx = noise_comp();
            hy = noise_comp();
        end
    endfunction

    // directed table builders
    function automatic void add_heading(input logic [HW-1:0] hx, input logic [HW-1:0] hy);
        step_t s;
        s = '0;
        s.hx = hx;
        s.hy = hy;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_typed(input logic [HW-1:0] hx, input logic [HW-1:0] hy,
                                      input logic [SPD_W-1:0] l, input logic [SPD_W-1:0] r,
                                      input turn_t m);
        step_t s;
        s = '0;
        s.hx         = hx;
        s.hy         = hy;
        s.typed      = 1'b1;
        s.want.left  = l;
        s.want.right = r;
        s.want.mode  = m;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        step_t s;
        s = '0;
        s.is_write = 1'b1;
        s.idx      = idx;
        s.val      = val;
        directed_steps.push_back(s);
    endfunction

    // one heading request; the expectation is stored when it is accepted
    task automatic send_heading(input logic [HW-1:0] hx, input logic [HW-1:0] hy,
                                input bit typed, input wheels_t want);
        int gap;
        wheels_t guess;
        gap = next_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {hy, hx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        guess = predict_wheels(hx, hy);
        wheels_due.push_back(typed ? want : guess);
        headings_sent++;
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (wheels_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (idx)
            CFG_MAX_SPEED: max_speed_r = val;
            CFG_HARD_THR:  hard_thr_r  = val;
            CFG_SOFT_THR:  soft_thr_r  = val;
            CFG_NO_THR:    no_thr_r    = val;
        endcase
        configs_written++;
    endtask

    // stimulus
    initial begin : stimulus
        step_t row;
        logic [HW-1:0] hx, hy;
        logic [CFG_W-1:0] ta, tb, tc, tt;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MAX_SPEED;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        max_speed_r = MAX_SPEED_RST;
        hard_thr_r  = HARD_THR_RST;
        soft_thr_r  = SOFT_THR_RST;
        no_thr_r    = NO_THR_RST;
        steer_state = TURN_NONE;

        // directed table: reset defaults first, then register extremes
        add_typed(16'h0000, 16'h0000, 17'd0, 17'd0, TURN_NONE);
        add_typed(16'h7FFF, 16'h0000, 17'd2560, 17'd2560, TURN_NONE);
        add_heading(16'h0000, 16'h7FFF);
        add_heading(16'h0000, 16'h8000);
        add_heading(16'h8000, 16'h0000);
        add_heading(16'h8000, 16'h7FFF);
        add_heading(16'h8000, 16'h8000);
        add_heading(16'h7FFF, 16'h7FFF);
        add_heading(16'h7FFF, 16'h8000);
        add_heading(16'hFFFF, 16'hFFFF);
        add_heading(16'h0001, 16'hFFFF);
        add_heading(16'h8000, 16'h0001);
        add_heading(16'h8000, 16'hFFFF);
        // zero max speed: hard turn near pi gives zero on both wheels
        add_write(CFG_MAX_SPEED, '0);
        add_typed(16'h8000, 16'h0000, 17'd0, 17'd0, TURN_HARD);
        // all thresholds at zero
        add_write(CFG_MAX_SPEED, REG_TOP);
        add_write(CFG_HARD_THR, '0);
        add_write(CFG_SOFT_THR, '0);
        add_write(CFG_NO_THR, '0);
        add_heading(16'h0000, 16'h0000);
        add_heading(16'd100, -16'sd3000);
        add_heading(-16'sd20000, 16'd5);
        // all thresholds at the top
        add_write(CFG_HARD_THR, REG_TOP);
        add_write(CFG_SOFT_THR, REG_TOP);
        add_write(CFG_NO_THR, REG_TOP);
        add_heading(16'h8000, 16'h0000);
        add_heading(16'd20000, 16'd20000);
        // thresholds out of order
        add_write(CFG_HARD_THR, 15'd4000);
        add_write(CFG_SOFT_THR, 15'd30000);
        add_write(CFG_NO_THR, 15'd8000);
        add_heading(16'd100, 16'd8000);
        add_heading(16'd100, -16'sd8000);
        add_heading(16'd8000, 16'd8000);
        add_heading(16'd30000, 16'd100);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[k]) begin
            row = directed_steps[k];
            if (row.is_write) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                send_heading(row.hx, row.hy, row.typed, row.want);
            end
        end

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            if (p == 0) begin
                write_reg(CFG_MAX_SPEED, MAX_SPEED_RST);
                write_reg(CFG_HARD_THR, HARD_THR_RST);
                write_reg(CFG_SOFT_THR, SOFT_THR_RST);
                write_reg(CFG_NO_THR, NO_THR_RST);
            end else begin
                ta = rand_reg();
                tb = rand_reg();
                tc = rand_reg();
                // half the time keep the usual ordering no <= soft <= hard
                if ($urandom_range(0, 1)) begin
                    if (ta > tb) begin tt = ta; ta = tb; tb = tt; end
                    if (tb > tc) begin tt = tb; tb = tc; tc = tt; end
                    if (ta > tb) begin tt = ta; ta = tb; tb = tt; end
                end
                write_reg(CFG_MAX_SPEED, rand_reg());
                write_reg(CFG_HARD_THR, tc);
                write_reg(CFG_SOFT_THR, tb);
                write_reg(CFG_NO_THR, ta);
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                next_heading(hx, hy);
                send_heading(hx, hy, 1'b0, '0);
            end
        end

        settle();
        $display("covered %0d headings across %0d register writes (extremes, zero and",
                 headings_sent, configs_written);
        $display("out-of-order thresholds); turn modes seen none/soft/hard: %0d/%0d/%0d",
                 mode_seen[0], mode_seen[1], mode_seen[2]);
        if (fail_count == 0 && wheels_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // result side: random stalls, field-by-field compare against the oldest expectation
    initial begin : result_check
        int gap;
        wheels_t got, want;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = next_gap(take_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.left  = m_tdata[16:0];
            got.right = m_tdata[33:17];
            got.mode  = turn_t'(m_tdata[35:34]);
            if (got.mode <= TURN_HARD) mode_seen[got.mode]++;
            if (wheels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: left %0d right %0d mode %0d",
                             $signed(got.left), $signed(got.right), got.mode);
            end else begin
                want = wheels_due.pop_front();
                if (got.left !== want.left || got.right !== want.right
                    || got.mode !== want.mode) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: expected left %0d right %0d mode %0d",
                                 $signed(want.left), $signed(want.right), want.mode);
                        $display("          got left %0d right %0d mode %0d",
                                 $signed(got.left), $signed(got.right), got.mode);
                    end
                end
            end
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
